// ===== design/mrc_pkg.sv =====
`default_nettype none

package mrc_pkg;

	// CRC-16 as used on Modbus RTU lines: reflected polynomial, all-ones seed.
	localparam logic [15:0] CRC_SEED = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	// Frame layout constants.
	localparam logic [3:0] COUNT_MAX     = 4'd15;
	localparam logic [3:0] LEN_MIN       = 4'd5;
	localparam logic [3:0] LEN_EXCEPTION = 4'd5;
	localparam logic [3:0] LEN_READ      = 4'd9;
	localparam logic [3:0] LEN_OTHER     = 4'd8;
	localparam logic [3:0] POS_ADDRESS   = 4'd0;
	localparam logic [3:0] POS_FUNCTION  = 4'd1;
	localparam logic [3:0] POS_THIRD     = 4'd2;
	localparam logic [3:0] POS_VAL_FIRST = 4'd3;
	localparam logic [3:0] POS_VAL_LAST  = 4'd6;
	localparam logic [6:0] READ_FUNCTION = 7'h03;
	localparam logic [7:0] READ_BYTE_CNT = 8'h04;

	// Configuration register indexes.
	localparam logic REG_ADDRESS  = 1'b0;
	localparam logic REG_FUNCTION = 1'b1;

	// Response status codes, in order of precedence after OK.
	localparam logic [3:0] ST_OK        = 4'd0;
	localparam logic [3:0] ST_SHORT     = 4'd1;
	localparam logic [3:0] ST_CRC       = 4'd2;
	localparam logic [3:0] ST_ADDRESS   = 4'd3;
	localparam logic [3:0] ST_EXC_LEN   = 4'd4;
	localparam logic [3:0] ST_EXCEPTION = 4'd5;
	localparam logic [3:0] ST_FUNCTION  = 4'd6;
	localparam logic [3:0] ST_LENGTH    = 4'd7;
	localparam logic [3:0] ST_BYTE_CNT  = 4'd8;

	// Everything the classifier needs to know about a finished frame.
	typedef struct packed {
		logic [3:0]  len;
		logic [15:0] crc;
		logic [7:0]  address;
		logic [7:0]  func;
		logic [7:0]  third;
		logic [31:0] value;
	} frame_sum_t;

	// One classified result.
	typedef struct packed {
		logic [31:0] read_value;
		logic [7:0]  exception_code;
		logic [3:0]  status;
	} result_t;

	// Bytewise CRC update, one bit per step.
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== design/mrc_frame.sv =====
`default_nettype none

module mrc_frame
	import mrc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,
	input  wire logic       s_tlast,
	input  wire logic       out_room,
	output logic            res_valid,
	output frame_sum_t      summary
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        advance;

	logic [15:0] crc_q;
	logic [3:0]  count_q;
	logic [7:0]  address_q;
	logic [7:0]  func_q;
	logic [7:0]  third_q;
	logic [31:0] value_q;

	frame_sum_t  nxt;

	// The staged byte moves on unless it closes a frame and the result slot is full.
	assign advance  = valid_s1 && (!last_s1 || out_room);
	assign s_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	// Frame state after the staged byte is folded in.
	always_comb begin
		nxt.crc     = crc_update(crc_q, byte_s1);
		nxt.len     = (count_q == COUNT_MAX) ? COUNT_MAX : count_q + 4'd1;
		nxt.address = (count_q == POS_ADDRESS)  ? byte_s1 : address_q;
		nxt.func    = (count_q == POS_FUNCTION) ? byte_s1 : func_q;
		nxt.third   = (count_q == POS_THIRD)    ? byte_s1 : third_q;
		if (count_q >= POS_VAL_FIRST && count_q <= POS_VAL_LAST) begin
			nxt.value = {value_q[23:0], byte_s1};
		end else begin
			nxt.value = value_q;
		end
	end

	assign summary   = nxt;
	assign res_valid = valid_s1 && last_s1;

	// Running frame state; cleared once the closing byte has gone through.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q     <= CRC_SEED;
			count_q   <= '0;
			address_q <= '0;
			func_q    <= '0;
			third_q   <= '0;
			value_q   <= '0;
		end else if (advance) begin
			if (last_s1) begin
				crc_q     <= CRC_SEED;
				count_q   <= '0;
				address_q <= '0;
				func_q    <= '0;
				third_q   <= '0;
				value_q   <= '0;
			end else begin
				crc_q     <= nxt.crc;
				count_q   <= nxt.len;
				address_q <= nxt.address;
				func_q    <= nxt.func;
				third_q   <= nxt.third;
				value_q   <= nxt.value;
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/mrc_classify.sv =====
`default_nettype none

module mrc_classify
	import mrc_pkg::*;
(
	input  wire frame_sum_t  summary,
	input  wire logic [7:0]  expected_address,
	input  wire logic [6:0]  expected_function,
	output result_t          result
);

	logic       is_read;
	logic [3:0] want_len;

	assign is_read  = (expected_function == READ_FUNCTION);
	assign want_len = is_read ? LEN_READ : LEN_OTHER;

	// Checks in order of precedence; the first failing one decides the status.
	always_comb begin
		result.exception_code = '0;
		result.read_value     = '0;
		if (summary.len < LEN_MIN) begin
			result.status = ST_SHORT;
		end else if (summary.crc != 16'h0000) begin
			result.status = ST_CRC;
		end else if (summary.address != expected_address) begin
			result.status = ST_ADDRESS;
		end else if (summary.func == {1'b1, expected_function}) begin
			if (summary.len != LEN_EXCEPTION) begin
				result.status = ST_EXC_LEN;
			end else begin
				result.status         = ST_EXCEPTION;
				result.exception_code = summary.third;
			end
		end else if (summary.func != {1'b0, expected_function}) begin
			result.status = ST_FUNCTION;
		end else if (summary.len != want_len) begin
			result.status = ST_LENGTH;
		end else if (is_read && summary.third != READ_BYTE_CNT) begin
			result.status = ST_BYTE_CNT;
		end else begin
			result.status = ST_OK;
			if (is_read) begin
				// Registers arrive low word first, each word big-endian.
				result.read_value = {summary.value[15:0], summary.value[31:16]};
			end
		end
	end

endmodule

`default_nettype wire

// ===== design/modbus_rtu_response_checker.sv =====
// Modbus RTU response checker.
// The slave-side stream carries one response byte per request in s_tdata, with
// s_tlast high on the final byte of the frame. Every byte updates a running
// CRC-16 and the header capture; no result is given for bytes without s_tlast.
// For each closing byte one result comes out on the master-side stream:
// m_tdata holds status, exception code and the word-swapped read value.
// A closing byte passes the input register; its result is loaded into the
// output register once the slot is free. One byte is accepted per cycle
// unless a closing byte waits; the CRC update and the status checks together
// fit between the input and output registers. The user must set the expected
// address and function through the cfg port while no frame is in flight; the
// block does not enforce this. Reset returns the CRC to all ones, clears the
// byte count and captured header, and sets the address to 1 and function to 3.
// When m_tready is low the result waits in the output register; bytes that
// do not end a frame flow in, and a closing byte waits in the input register.
`default_nettype none

module modbus_rtu_response_checker
	import mrc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  wire logic        s_tlast,   // last_byte
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // [3:0] status, [11:4] exception_code,
	                                    // [43:12] read_value, [47:44] zero
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [7:0]  cfg_data
);

	logic [7:0] exp_address_q;
	logic [6:0] exp_function_q;
	logic       out_room;
	logic       res_valid;
	frame_sum_t summary;
	result_t    result;
	result_t    out_q;
	logic       out_valid_q;
	logic       out_load;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_address_q  <= 8'd1;
			exp_function_q <= READ_FUNCTION;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ADDRESS:  exp_address_q  <= cfg_data;
				REG_FUNCTION: exp_function_q <= cfg_data[6:0];
				default:      ;
			endcase
		end
	end

	assign out_room = !out_valid_q || m_tready;

	mrc_frame u_frame (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.out_room  (out_room),
		.res_valid (res_valid),
		.summary   (summary)
	);

	mrc_classify u_classify (
		.summary           (summary),
		.expected_address  (exp_address_q),
		.expected_function (exp_function_q),
		.result            (result)
	);

	// Output register.
	assign out_load = res_valid && out_room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'h0, out_q.read_value, out_q.exception_code, out_q.status};

`ifndef ASSERT_OFF
	// A read value only accompanies a good frame.
	a_value_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_q.status != ST_OK) |-> (out_q.read_value == 32'h0))
		else $error("read value given with failing status");

	// An exception code only accompanies a reported exception.
	a_exc_only_exc: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_q.status != ST_EXCEPTION) |-> (out_q.exception_code == 8'h0))
		else $error("exception code given without exception status");

	// A closing byte is never taken while the result slot is blocked.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !out_load)
		else $error("stalled result overwritten");

	// A new result appears only after a closing byte was staged.
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(res_valid))
		else $error("result without closing byte");
`endif

endmodule

`default_nettype wire
